// ===== hw/rtl/hst_pkg.sv =====
// Shared types and constants for the handle slot table.
package hst_pkg;

   // Table geometry
   localparam int TABLE_SIZE = 16;
   localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

   // Field widths
   localparam int OP_W     = 3;
   localparam int SLOT_W   = 6;
   localparam int HANDLE_W = 64;
   localparam int ACT_W    = 2;

   // All-ones handle value; alloc refuses it as a handle, as it refuses zero
   localparam logic [HANDLE_W-1:0] FREE_MARK = '1;

   // Operation codes
   localparam logic [OP_W-1:0] OP_ALLOC     = 3'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP    = 3'd1;
   localparam logic [OP_W-1:0] OP_CLOSE     = 3'd2;
   localparam logic [OP_W-1:0] OP_DUP       = 3'd3;
   localparam logic [OP_W-1:0] OP_DUP2      = 3'd4;
   localparam logic [OP_W-1:0] OP_CLOSE_ALL = 3'd5;

   // Action codes
   localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_RETAIN  = 2'd2;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOOK,
      ST_D2_REL,
      ST_D2_SRC,
      ST_D2_CPY,
      ST_CA_SCAN,
      ST_CA_REL,
      ST_OUT
   } state_type;

   // Result templates the datapath can build
   typedef enum logic [3:0] {
      RES_ERROR,
      RES_ALLOC,
      RES_LOOKUP,
      RES_CLOSE,
      RES_DUP,
      RES_D2_EQ,
      RES_D2_REL,
      RES_D2_CPY,
      RES_CA_REL,
      RES_CA_EMPTY
   } res_type;

   // Read address sources
   typedef enum logic [1:0] {
      RD_SLOT,
      RD_TARGET,
      RD_SCAN
   } rd_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic       capture;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       res_load;
      res_type    res_kind;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            slot_ok;
      logic            target_ok;
      logic            src_occ;
      logic            tgt_occ;
      logic            free_found;
      logic            handle_bad;
      logic            equal;
      logic            any_occ;
      logic            res_last;
   } stat_type;

endpackage

// ===== hw/rtl/hst_datapath.sv =====
// Slot memory, occupancy bits, slot search and result register.
module hst_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  hst_pkg::cmd_type                cmd,
   output hst_pkg::stat_type               stat,
   input  logic [hst_pkg::OP_W-1:0]        in_operation,
   input  logic [hst_pkg::SLOT_W-1:0]      in_slot,
   input  logic [hst_pkg::SLOT_W-1:0]      in_target_slot,
   input  logic [hst_pkg::HANDLE_W-1:0]    in_handle,
   output logic                            out_status,
   output logic [hst_pkg::SLOT_W-1:0]      out_slot_index,
   output logic [hst_pkg::HANDLE_W-1:0]    out_handle,
   output logic [hst_pkg::ACT_W-1:0]       out_action,
   output logic                            out_last
);

   // Captured request beat
   logic [hst_pkg::OP_W-1:0]     op_ff;
   logic [hst_pkg::SLOT_W-1:0]   slot_ff;
   logic [hst_pkg::SLOT_W-1:0]   target_ff;
   logic [hst_pkg::HANDLE_W-1:0] handle_ff;

   // Occupancy and memory
   logic [hst_pkg::TABLE_SIZE-1:0] occ_ff, occ_in;
   logic [hst_pkg::HANDLE_W-1:0]   mem [hst_pkg::TABLE_SIZE];
   logic [hst_pkg::HANDLE_W-1:0]   rdata_ff;
   logic [hst_pkg::IDX_W-1:0]      scan_ff, scan_in;

   // Result register
   logic                         res_status_ff, res_status_in;
   logic [hst_pkg::SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [hst_pkg::HANDLE_W-1:0] res_handle_ff, res_handle_in;
   logic [hst_pkg::ACT_W-1:0]    res_action_ff, res_action_in;
   logic                         res_last_ff, res_last_in;

   // Decode helpers
   logic [hst_pkg::IDX_W-1:0]      slot_idx, target_idx, free_idx, occ_idx, rd_addr, wr_addr;
   logic                           free_found, slot_ok, target_ok, src_occ, tgt_occ;
   logic [hst_pkg::TABLE_SIZE-1:0] scan_mask;
   logic [hst_pkg::SLOT_W-1:0]     err_slot;
   logic                           wr_en;
   logic [hst_pkg::HANDLE_W-1:0]   wr_data;

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= in_operation;
         slot_ff   <= in_slot;
         target_ff <= in_target_slot;
         handle_ff <= in_handle;
      end
   end

   // Range and occupancy checks
   assign slot_ok    = {1'b0, slot_ff} < (hst_pkg::SLOT_W + 1)'(hst_pkg::TABLE_SIZE);
   assign target_ok  = {1'b0, target_ff} < (hst_pkg::SLOT_W + 1)'(hst_pkg::TABLE_SIZE);
   assign slot_idx   = slot_ff[hst_pkg::IDX_W-1:0];
   assign target_idx = target_ff[hst_pkg::IDX_W-1:0];
   assign src_occ    = slot_ok && occ_ff[slot_idx];
   assign tgt_occ    = target_ok && occ_ff[target_idx];

   // Lowest free and lowest occupied slot
   always_comb begin
      free_idx   = '0;
      free_found = 1'b0;
      occ_idx    = '0;
      for (int i = hst_pkg::TABLE_SIZE - 1; i >= 0; i--) begin
         if (!occ_ff[i]) begin
            free_idx   = hst_pkg::IDX_W'(i);
            free_found = 1'b1;
         end
         if (occ_ff[i]) begin
            occ_idx = hst_pkg::IDX_W'(i);
         end
      end
   end

   // Mask of the slot under close-all
   always_comb begin
      for (int i = 0; i < hst_pkg::TABLE_SIZE; i++) begin
         scan_mask[i] = (hst_pkg::IDX_W'(i) == scan_ff);
      end
   end

   // Status toward the controller
   always_comb begin
      stat.op         = op_ff;
      stat.slot_ok    = slot_ok;
      stat.target_ok  = target_ok;
      stat.src_occ    = src_occ;
      stat.tgt_occ    = tgt_occ;
      stat.free_found = free_found;
      stat.handle_bad = (handle_ff == '0) || (handle_ff == hst_pkg::FREE_MARK);
      stat.equal      = (slot_ff == target_ff);
      stat.any_occ    = |occ_ff;
      stat.res_last   = res_last_ff;
   end

   // Read address select
   always_comb begin
      case (cmd.rd_sel)
         hst_pkg::RD_SLOT:   rd_addr = slot_idx;
         hst_pkg::RD_TARGET: rd_addr = target_idx;
         hst_pkg::RD_SCAN:   rd_addr = occ_idx;
         default:            rd_addr = slot_idx;
      endcase
   end

   // Slot index reported on an error
   always_comb begin
      case (op_ff)
         hst_pkg::OP_ALLOC: err_slot = '0;
         hst_pkg::OP_DUP2:  err_slot = target_ff;
         default:           err_slot = slot_ff;
      endcase
   end

   // Build the result, table write and occupancy update
   always_comb begin
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_handle_in = res_handle_ff;
      res_action_in = res_action_ff;
      res_last_in   = res_last_ff;
      occ_in        = occ_ff;
      wr_en         = 1'b0;
      wr_addr       = free_idx;
      wr_data       = handle_ff;
      scan_in       = scan_ff;
      if (cmd.rd_en && cmd.rd_sel == hst_pkg::RD_SCAN) begin
         scan_in = occ_idx;
      end
      if (cmd.res_load) begin
         res_status_in = 1'b0;
         res_handle_in = '0;
         res_action_in = hst_pkg::ACT_NONE;
         res_last_in   = 1'b1;
         case (cmd.res_kind)
            hst_pkg::RES_ERROR: begin
               res_status_in = 1'b1;
               res_slot_in   = err_slot;
            end
            hst_pkg::RES_ALLOC: begin
               res_slot_in      = hst_pkg::SLOT_W'(free_idx);
               res_handle_in    = handle_ff;
               wr_en            = 1'b1;
               occ_in[free_idx] = 1'b1;
            end
            hst_pkg::RES_LOOKUP: begin
               res_slot_in   = slot_ff;
               res_handle_in = rdata_ff;
            end
            hst_pkg::RES_CLOSE: begin
               res_slot_in      = slot_ff;
               res_handle_in    = rdata_ff;
               res_action_in    = hst_pkg::ACT_RELEASE;
               occ_in[slot_idx] = 1'b0;
            end
            hst_pkg::RES_DUP: begin
               res_slot_in      = hst_pkg::SLOT_W'(free_idx);
               res_handle_in    = rdata_ff;
               res_action_in    = hst_pkg::ACT_RETAIN;
               wr_en            = 1'b1;
               wr_data          = rdata_ff;
               occ_in[free_idx] = 1'b1;
            end
            hst_pkg::RES_D2_EQ: begin
               res_slot_in = target_ff;
            end
            hst_pkg::RES_D2_REL: begin
               res_slot_in   = target_ff;
               res_handle_in = rdata_ff;
               res_action_in = hst_pkg::ACT_RELEASE;
               res_last_in   = 1'b0;
            end
            hst_pkg::RES_D2_CPY: begin
               res_slot_in        = target_ff;
               res_handle_in      = rdata_ff;
               res_action_in      = hst_pkg::ACT_RETAIN;
               wr_en              = 1'b1;
               wr_addr            = target_idx;
               wr_data            = rdata_ff;
               occ_in[target_idx] = 1'b1;
            end
            hst_pkg::RES_CA_REL: begin
               res_slot_in   = hst_pkg::SLOT_W'(scan_ff);
               res_handle_in = rdata_ff;
               res_action_in = hst_pkg::ACT_RELEASE;
               res_last_in   = ((occ_ff & ~scan_mask) == '0);
               occ_in        = occ_ff & ~scan_mask;
            end
            hst_pkg::RES_CA_EMPTY: begin
               res_slot_in = '0;
            end
            default: begin
               res_status_in = 1'b1;
               res_slot_in   = err_slot;
            end
         endcase
      end
   end

   // Slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Occupancy bits
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // Scan index and result register
   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_handle_ff <= res_handle_in;
      res_action_ff <= res_action_in;
      res_last_ff   <= res_last_in;
   end

   assign out_status     = res_status_ff;
   assign out_slot_index = res_slot_ff;
   assign out_handle     = res_handle_ff;
   assign out_action     = res_action_ff;
   assign out_last       = res_last_ff;

   // A new entry only ever lands in a free slot
   a_alloc_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.res_load && (cmd.res_kind == hst_pkg::RES_ALLOC ||
                        cmd.res_kind == hst_pkg::RES_DUP)) |-> free_found)
      else $error("allocation without a free slot");

   // A close-all release frees the slot it names
   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.res_load && cmd.res_kind == hst_pkg::RES_CA_REL) |=> !occ_ff[$past(scan_ff)])
      else $error("released slot still occupied");

endmodule

// ===== hw/rtl/hst_controller.sv =====
// Sequencer that steps the datapath through each operation.
module hst_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  hst_pkg::stat_type  stat,
   output hst_pkg::cmd_type   cmd
);

   hst_pkg::state_type  state_ff, state_in;

   // Decision taken in the decode state
   hst_pkg::state_type  dec_next;
   logic                dec_load;
   hst_pkg::res_type    dec_kind;
   logic                dec_rd;
   hst_pkg::rd_sel_type dec_sel;
   hst_pkg::res_type    look_kind;

   // Check the captured beat and pick the first step
   always_comb begin
      dec_next = hst_pkg::ST_OUT;
      dec_load = 1'b1;
      dec_kind = hst_pkg::RES_ERROR;
      dec_rd   = 1'b0;
      dec_sel  = hst_pkg::RD_SLOT;
      case (stat.op)
         hst_pkg::OP_ALLOC: begin
            if (!stat.handle_bad && stat.free_found) begin
               dec_kind = hst_pkg::RES_ALLOC;
            end
         end
         hst_pkg::OP_LOOKUP, hst_pkg::OP_CLOSE: begin
            if (stat.src_occ) begin
               dec_load = 1'b0;
               dec_rd   = 1'b1;
               dec_next = hst_pkg::ST_LOOK;
            end
         end
         hst_pkg::OP_DUP: begin
            if (stat.src_occ && stat.free_found) begin
               dec_load = 1'b0;
               dec_rd   = 1'b1;
               dec_next = hst_pkg::ST_LOOK;
            end
         end
         hst_pkg::OP_DUP2: begin
            if (stat.slot_ok && stat.target_ok) begin
               if (stat.equal) begin
                  dec_kind = hst_pkg::RES_D2_EQ;
               end else if (stat.src_occ) begin
                  dec_load = 1'b0;
                  if (stat.tgt_occ) begin
                     dec_rd   = 1'b1;
                     dec_sel  = hst_pkg::RD_TARGET;
                     dec_next = hst_pkg::ST_D2_REL;
                  end else begin
                     dec_next = hst_pkg::ST_D2_SRC;
                  end
               end
            end
         end
         hst_pkg::OP_CLOSE_ALL: begin
            if (stat.any_occ) begin
               dec_load = 1'b0;
               dec_next = hst_pkg::ST_CA_SCAN;
            end else begin
               dec_kind = hst_pkg::RES_CA_EMPTY;
            end
         end
         default: begin
            dec_kind = hst_pkg::RES_ERROR;
         end
      endcase
   end

   // Result for a single read operation
   always_comb begin
      case (stat.op)
         hst_pkg::OP_LOOKUP: look_kind = hst_pkg::RES_LOOKUP;
         hst_pkg::OP_CLOSE:  look_kind = hst_pkg::RES_CLOSE;
         default:            look_kind = hst_pkg::RES_DUP;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hst_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = hst_pkg::ST_DECODE;
            end
         end
         hst_pkg::ST_DECODE:  state_in = dec_next;
         hst_pkg::ST_LOOK:    state_in = hst_pkg::ST_OUT;
         hst_pkg::ST_D2_REL:  state_in = hst_pkg::ST_OUT;
         hst_pkg::ST_D2_SRC:  state_in = hst_pkg::ST_D2_CPY;
         hst_pkg::ST_D2_CPY:  state_in = hst_pkg::ST_OUT;
         hst_pkg::ST_CA_SCAN: state_in = hst_pkg::ST_CA_REL;
         hst_pkg::ST_CA_REL:  state_in = hst_pkg::ST_OUT;
         hst_pkg::ST_OUT: begin
            if (rsp_tready) begin
               if (stat.res_last) begin
                  state_in = hst_pkg::ST_IDLE;
               end else if (stat.op == hst_pkg::OP_DUP2) begin
                  state_in = hst_pkg::ST_D2_SRC;
               end else begin
                  state_in = hst_pkg::ST_CA_SCAN;
               end
            end
         end
         default: state_in = hst_pkg::ST_IDLE;
      endcase
   end

   // Commands and handshake outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         hst_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         hst_pkg::ST_DECODE: begin
            cmd.rd_en    = dec_rd;
            cmd.rd_sel   = dec_sel;
            cmd.res_load = dec_load;
            cmd.res_kind = dec_kind;
         end
         hst_pkg::ST_LOOK: begin
            cmd.res_load = 1'b1;
            cmd.res_kind = look_kind;
         end
         hst_pkg::ST_D2_REL: begin
            cmd.res_load = 1'b1;
            cmd.res_kind = hst_pkg::RES_D2_REL;
         end
         hst_pkg::ST_D2_SRC: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = hst_pkg::RD_SLOT;
         end
         hst_pkg::ST_D2_CPY: begin
            cmd.res_load = 1'b1;
            cmd.res_kind = hst_pkg::RES_D2_CPY;
         end
         hst_pkg::ST_CA_SCAN: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = hst_pkg::RD_SCAN;
         end
         hst_pkg::ST_CA_REL: begin
            cmd.res_load = 1'b1;
            cmd.res_kind = hst_pkg::RES_CA_REL;
         end
         hst_pkg::ST_OUT: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hst_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Close-all only releases while something is occupied
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hst_pkg::ST_CA_REL) |-> stat.any_occ)
      else $error("close-all release with an empty table");

   // The copy step of dup2 still sees an occupied source
   a_copy_source: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hst_pkg::ST_D2_CPY) |-> stat.src_occ)
      else $error("dup2 copy from a free slot");

   // The release ahead of a dup2 copy never closes the run
   a_release_not_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hst_pkg::ST_D2_REL) |=> !stat.res_last)
      else $error("dup2 release marked last");

endmodule

// ===== hw/rtl/handle_slot_table.sv =====
// Top level of the handle slot table: stream ports around controller and datapath.
//
// A table of 16 handle slots, all free after reset. Each request beat carries
// one operation and answers with one or more response beats, the final one
// marked by rsp_tlast. One request is in work at a time. Alloc and every error
// pass through capture, decode and result steps; lookup, close and dup add a
// read step before the result, because the slot memory has one registered read
// port. Dup2 onto an occupied slot gives a release and, once that beat is
// taken, the retain. Close-all gives one release beat per occupied slot, lowest
// first, and each beat waits on rsp_tready. A new request is accepted the cycle
// after the last response beat is taken.
module handle_slot_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // slot[5:0], target_slot[11:6], handle[75:12], zero pad
   input  logic [2:0]  req_tuser,  // operation[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // status[0], slot_index[6:1], handle_out[70:7], zero pad
   output logic [1:0]  rsp_tuser,  // action[1:0]
   output logic        rsp_tlast
);

   hst_pkg::cmd_type  cmd;
   hst_pkg::stat_type stat;

   logic                         out_status;
   logic [hst_pkg::SLOT_W-1:0]   out_slot_index;
   logic [hst_pkg::HANDLE_W-1:0] out_handle;
   logic [hst_pkg::ACT_W-1:0]    out_action;

   hst_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   hst_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .in_operation   (req_tuser),
      .in_slot        (req_tdata[5:0]),
      .in_target_slot (req_tdata[11:6]),
      .in_handle      (req_tdata[75:12]),
      .out_status     (out_status),
      .out_slot_index (out_slot_index),
      .out_handle     (out_handle),
      .out_action     (out_action),
      .out_last       (rsp_tlast)
   );

   // Pack the response beat
   assign rsp_tdata = {1'b0, out_handle, out_slot_index, out_status};
   assign rsp_tuser = out_action;

endmodule
